FILE: design/day_of_week_from_date_macros.svh
// Assertion macros for the weekday block and its port checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef DAY_OF_WEEK_FROM_DATE_MACROS_SVH
`define DAY_OF_WEEK_FROM_DATE_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define DOWFD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication form of the same.
`define DOWFD_ASSERT_IMP(label, ante, cons, msg) \
	`DOWFD_ASSERT(label, (ante) |-> (cons), msg)

`endif

FILE: design/dowfd_pkg.sv
// Shared types, constants and the month-length table for the weekday block.
// No dependencies.
package dowfd_pkg;

	localparam int unsigned YEAR_W = 14;
	localparam int unsigned DAY_W  = 5;
	localparam int unsigned MON_W  = 4;
	localparam int unsigned WD_W   = 3;
	localparam int unsigned ADD_W  = 6;

	localparam logic [YEAR_W-1:0] BASE_YEAR    = 14'd1900;
	localparam logic [WD_W-1:0]   BASE_WEEKDAY = 3'd2;   // 1 Jan 1900, Monday
	localparam logic [8:0]        BASE_MOD400  = 9'd300; // 1900 mod 400

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_YEARS,
		ST_MONTHS,
		ST_FINAL
	} state_t;

	// Year counter control
	typedef struct packed {
		logic load;      // restart the walk
		logic from_base; // start at 1900, else at year 0
		logic step;      // advance one year
	} yr_ctl_t;

	// Month length modulo 7: 31 -> 3, 30 -> 2, 28/29 -> 0/1
	function automatic logic [WD_W-1:0] month_len_mod7(input logic [MON_W-1:0] m,
		input logic leap);
		logic [WD_W-1:0] r;
		case (m) inside
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 3'd3;
			4'd4, 4'd6, 4'd9, 4'd11:                    r = 3'd2;
			default:                                    r = {2'b00, leap};
		endcase
		return r;
	endfunction

endpackage

FILE: design/dowfd_year_ctr.sv
// Year walker: current year plus its residues mod 4, 100 and 400, and a leap flag.
// Depends on dowfd_pkg.
module dowfd_year_ctr (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dowfd_pkg::yr_ctl_t            ctl,
	output logic [dowfd_pkg::YEAR_W-1:0]  year,
	output logic                          leap
);
	import dowfd_pkg::*;

	logic [YEAR_W-1:0] year_q;
	logic [1:0]        m4_q;
	logic [6:0]        m100_q;
	logic [8:0]        m400_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q <= '0;
			m4_q   <= '0;
			m100_q <= '0;
			m400_q <= '0;
		end else if (ctl.load) begin
			year_q <= ctl.from_base ? BASE_YEAR : '0;
			m4_q   <= '0;
			m100_q <= '0;
			m400_q <= ctl.from_base ? BASE_MOD400 : '0;
		end else if (ctl.step) begin
			year_q <= year_q + 1'b1;
			m4_q   <= m4_q + 1'b1;
			m100_q <= (m100_q == 7'd99) ? 7'd0 : m100_q + 1'b1;
			m400_q <= (m400_q == 9'd399) ? 9'd0 : m400_q + 1'b1;
		end
	end

	assign year = year_q;
	assign leap = ((m4_q == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);

endmodule

FILE: design/dowfd_mod7_add.sv
// Shared adder: (a + b) mod 7 for a weekday and a small addend.
// Depends on dowfd_pkg.
module dowfd_mod7_add (
	input  logic [dowfd_pkg::WD_W-1:0]  a,
	input  logic [dowfd_pkg::ADD_W-1:0] b,
	output logic [dowfd_pkg::WD_W-1:0]  sum
);
	import dowfd_pkg::*;

	logic [ADD_W-1:0] raw;
	logic [3:0]       fold;

	// 8 = 1 mod 7: fold the high bits onto the low three, then one subtract
	always_comb begin
		raw  = ADD_W'(a) + b;
		fold = {1'b0, raw[2:0]} + {1'b0, raw[ADD_W-1:3]};
		sum  = (fold >= 4'd7) ? 3'(fold - 4'd7) : fold[2:0];
	end

endmodule

FILE: design/day_of_week_from_date.sv
// Weekday of a Gregorian date, 0 Saturday .. 6 Friday, counted from Monday 1 Jan 1900.
// After accept it walks the years from 1900 to the target year, then the months before the target
// month (month 0 counts as 1), then adds the day; below 1900 the walk adds nothing, so Jan 1 stays a Monday.
// A new date is taken only once the last one is done. A finished word may wait in the output
// register while the next date is taken; the final add stalls while it is full and not taken.
// Reset (arst_n low, asynchronous) empties the block. Depends on dowfd_pkg, dowfd_year_ctr, dowfd_mod7_add.
module day_of_week_from_date (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dowfd_pkg::DAY_W-1:0]  day_of_month,
	input  logic [dowfd_pkg::MON_W-1:0]  month_number,
	input  logic [dowfd_pkg::YEAR_W-1:0] year_number,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dowfd_pkg::WD_W-1:0]   weekday
);
	import dowfd_pkg::*;

	state_t state_q, state_d;

	// Captured date
	logic [DAY_W-1:0]  day_q;
	logic [MON_W-1:0]  month_q;
	logic [YEAR_W-1:0] year_q;

	// Running weekday, month cursor, leap flag of the target year
	logic [WD_W-1:0]  d_q;
	logic [MON_W-1:0] m_q;
	logic             leap_q;

	// Output register
	logic             out_valid_q;
	logic [WD_W-1:0]  weekday_q;

	logic              accept;
	logic              out_free;
	yr_ctl_t           yr_ctl;
	logic [YEAR_W-1:0] cur_year;
	logic              cur_leap;
	logic              year_done;
	logic              month_done;
	logic [ADD_W-1:0]  addend;
	logic [WD_W-1:0]   d_next;
	logic              d_en;

	dowfd_year_ctr u_year (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (yr_ctl),
		.year   (cur_year),
		.leap   (cur_leap)
	);

	// The one adder, shared by the year, month and day phases
	dowfd_mod7_add u_add (
		.a   (d_q),
		.b   (addend),
		.sum (d_next)
	);

	assign accept     = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;
	assign year_done  = (cur_year == year_q);
	assign month_done = (m_q >= month_q);

	// Sequencer: next state, year counter control, adder operand
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		yr_ctl    = '0;
		addend    = '0;
		d_en      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					yr_ctl.load      = 1'b1;
					yr_ctl.from_base = (year_number >= BASE_YEAR);
					state_d          = ST_YEARS;
				end
			end
			ST_YEARS: begin
				// each year from 1900 on shifts Jan 1 by one, two in a leap year
				addend = ADD_W'(1) + ADD_W'(cur_leap);
				if (year_done) begin
					state_d = ST_MONTHS;
				end else begin
					yr_ctl.step = 1'b1;
					d_en        = (cur_year >= BASE_YEAR);
				end
			end
			ST_MONTHS: begin
				addend = ADD_W'(month_len_mod7(m_q, leap_q));
				if (month_done) begin
					state_d = ST_FINAL;
				end else begin
					d_en = 1'b1;
				end
			end
			ST_FINAL: begin
				// day - 1 taken as day + 6 mod 7
				addend = ADD_W'(day_q) + ADD_W'(6);
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			day_q   <= day_of_month;
			month_q <= month_number;
			year_q  <= year_number;
			d_q     <= BASE_WEEKDAY;
		end else if (d_en) begin
			d_q <= d_next;
		end
		if (state_q == ST_YEARS && year_done) begin
			leap_q <= cur_leap;
			m_q    <= 4'd1;
		end else if (state_q == ST_MONTHS && !month_done) begin
			m_q <= m_q + 1'b1;
		end
	end

	// Output register: loaded from the final add, held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINAL && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINAL && out_free) begin
			weekday_q <= d_next;
		end
	end

	assign out_valid = out_valid_q;
	assign weekday   = weekday_q;

endmodule

FILE: design/dowfd_checker.sv
// Port-level checker for day_of_week_from_date, bound to the top level.
// Depends on dowfd_pkg and day_of_week_from_date_macros.svh.
`include "day_of_week_from_date_macros.svh"

module dowfd_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [dowfd_pkg::DAY_W-1:0]  day_of_month,
	input logic [dowfd_pkg::MON_W-1:0]  month_number,
	input logic [dowfd_pkg::YEAR_W-1:0] year_number,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [dowfd_pkg::WD_W-1:0]   weekday
);
	import dowfd_pkg::*;

	// a delivered weekday is never the unused code 7
	`DOWFD_ASSERT_IMP(a_wd_range, out_valid, weekday != 3'd7, "weekday out of range")

	// a stalled word holds
	`DOWFD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(weekday), "output word dropped or changed while stalled")

	// one date at a time: busy right after taking a word
	`DOWFD_ASSERT(a_busy, in_valid && in_ready |=> !in_ready, "input taken while busy")

	// returning to ready means a result has just been posted
	`DOWFD_ASSERT_IMP(a_done_posts, $rose(in_ready), out_valid, "ready again without a result")

endmodule

bind day_of_week_from_date dowfd_checker u_dowfd_checker (.*);
